FILE: hw/rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  // Register and character constants
  localparam logic        ModeEncode = 1'b0;
  localparam logic        ModeDecode = 1'b1;
  localparam logic [7:0]  PadChar    = 8'h3D;   // '='
  localparam int unsigned QueueDepth = 2;

  // Kind of a queued job
  typedef enum logic [1:0] {
    KIND_ENC,
    KIND_DEC,
    KIND_ERR
  } job_kind_e;

  // One group handed from the front end to the back end
  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] bits;   // group, first item in the high bits
    logic [2:0]  cnt;    // encode: non-pad chars, decode: bytes
    logic        last;
  } job_t;

  // Sextet to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Character to sextet; anything outside the alphabet gives zero
  function automatic logic [5:0] dec_sextet(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      v = 8'd0;
    end
    return v[5:0];
  endfunction

endpackage

FILE: hw/rtl/base64_codec_unit.sv
// ----------------------------------------------------------------------------
// base64_codec_unit
// Streaming base64 encoder/decoder with a one-bit mode register.
// ----------------------------------------------------------------------------
// Usage: write mode (0 encode, 1 decode) over the cfg channel while the block
// is idle; a write discards any partial group. The input side takes one word
// per cycle while the job queue has room and queues one job per completed
// or last group. The output side emits one word per cycle from the head job
// while the receiver is ready: four characters per encoded group (three
// input words), up to three bytes per decoded group (four input words), so
// sustained throughput is set by the output stage when encoding and by the
// input side when decoding. A decode message whose length is not a
// multiple of four ends in a single word with tuser (error) set and data zero.
module base64_codec_unit #(
  parameter int unsigned QueueDepth = b64_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,      // mode
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,  // last_byte
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o,  // out_last
  output logic       m_axis_tuser_o   // [0] error
);

  logic          q_push, q_pop, q_full, q_empty;
  b64_pkg::job_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_in)
  );

  b64_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .pop_i   (q_pop),
    .job_o   (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (m_axis_tuser_o)
  );

endmodule

FILE: hw/rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Input side: holds the mode register, gathers groups and queues a job per
// completed or last group (an error job for a short decode tail).
// ----------------------------------------------------------------------------
module b64_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output b64_pkg::job_t     q_job_o
);

  logic        mode_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  count_q, count_d;
  logic [1:0]  pads_q, pads_d;
  logic        accept;
  logic [2:0]  n;
  logic [5:0]  sextet;
  logic        is_pad;
  logic [1:0]  pads_new;
  logic [23:0] bits_new;
  logic [1:0]  pad_drop;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign n          = {1'b0, count_q} + 3'd1;
  assign is_pad     = (in_byte_i == b64_pkg::PadChar);
  assign sextet     = is_pad ? 6'd0 : b64_pkg::dec_sextet(in_byte_i);

  // Group gathering and job building
  always_comb begin
    pads_new = pads_q;
    pad_drop = 2'd0;
    bits_new = bits_q;
    bits_d   = bits_q;
    count_d  = count_q;
    pads_d   = pads_q;
    q_push_o = 1'b0;
    q_job_o  = '{kind: b64_pkg::KIND_ENC, bits: bits_q, cnt: 3'd0, last: in_last_i};
    if (mode_q == b64_pkg::ModeEncode) begin
      unique case (count_q)
        2'd0:    bits_new = bits_q | {in_byte_i, 16'h0000};
        2'd1:    bits_new = bits_q | {8'h00, in_byte_i, 8'h00};
        default: bits_new = bits_q | {16'h0000, in_byte_i};
      endcase
      q_job_o.kind = b64_pkg::KIND_ENC;
      q_job_o.bits = bits_new;
      q_job_o.cnt  = n + 3'd1;
      if (accept) begin
        if (n == 3'd3 || in_last_i) begin
          q_push_o = 1'b1;
          bits_d   = '0;
          count_d  = '0;
          pads_d   = '0;
        end else begin
          bits_d  = bits_new;
          count_d = n[1:0];
        end
      end
    end else begin
      unique case (count_q)
        2'd0: bits_new = bits_q | {sextet, 18'h00000};
        2'd1: bits_new = bits_q | {6'h00, sextet, 12'h000};
        2'd2: bits_new = bits_q | {12'h000, sextet, 6'h00};
        default: bits_new = bits_q | {18'h00000, sextet};
      endcase
      if (is_pad && count_q == 2'd2) pads_new[0] = 1'b1;
      if (is_pad && count_q == 2'd3) pads_new[1] = 1'b1;
      pad_drop = {1'b0, pads_new[0]} + {1'b0, pads_new[1]};
      q_job_o.bits = bits_new;
      if (n == 3'd4) begin
        q_job_o.kind = b64_pkg::KIND_DEC;
        q_job_o.cnt  = in_last_i ? 3'd3 - {1'b0, pad_drop} : 3'd3;
      end else begin
        q_job_o.kind = b64_pkg::KIND_ERR;
        q_job_o.cnt  = 3'd1;
      end
      if (accept) begin
        if (n == 3'd4 || in_last_i) begin
          q_push_o = 1'b1;
          bits_d   = '0;
          count_d  = '0;
          pads_d   = '0;
        end else begin
          bits_d  = bits_new;
          count_d = n[1:0];
          pads_d  = pads_new;
        end
      end
    end
  end

  // Mode register and group state; a mode write drops any partial group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= b64_pkg::ModeEncode;
      bits_q  <= '0;
      count_q <= '0;
      pads_q  <= '0;
    end else if (cfg_valid_i) begin
      mode_q  <= cfg_data_i;
      bits_q  <= '0;
      count_q <= '0;
      pads_q  <= '0;
    end else begin
      bits_q  <= bits_d;
      count_q <= count_d;
      pads_q  <= pads_d;
    end
  end

endmodule

FILE: hw/rtl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module b64_queue #(
  parameter int unsigned Depth = b64_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  b64_pkg::job_t job_i,
  input  logic          pop_i,
  output b64_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Output side: walks the head job one result per cycle into the output
// register while that register is free or being taken.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b64_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_err_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] n_res;
  logic       load, final_res;
  logic [5:0] sextet;
  logic [7:0] byte_d;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q, err_q;

  // Result count of the head job
  always_comb begin
    unique case (job_i.kind)
      b64_pkg::KIND_ENC: n_res = 3'd4;
      b64_pkg::KIND_DEC: n_res = job_i.cnt;
      default:           n_res = 3'd1;
    endcase
  end

  assign load      = (!valid_q || out_ready_i) && !empty_i;
  assign final_res = ({1'b0, idx_q} == n_res - 3'd1);
  assign pop_o     = load && final_res;
  assign idx_d     = final_res ? 2'd0 : idx_q + 2'd1;

  // Result value for the current index
  always_comb begin
    unique case (idx_q)
      2'd0:    sextet = job_i.bits[23:18];
      2'd1:    sextet = job_i.bits[17:12];
      2'd2:    sextet = job_i.bits[11:6];
      default: sextet = job_i.bits[5:0];
    endcase
    unique case (job_i.kind)
      b64_pkg::KIND_ENC: begin
        byte_d = ({1'b0, idx_q} < job_i.cnt) ? b64_pkg::enc_char(sextet)
                                             : b64_pkg::PadChar;
      end
      b64_pkg::KIND_DEC: begin
        unique case (idx_q)
          2'd0:    byte_d = job_i.bits[23:16];
          2'd1:    byte_d = job_i.bits[15:8];
          default: byte_d = job_i.bits[7:0];
        endcase
      end
      default: byte_d = 8'h00;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= job_i.last && final_res;
      err_q  <= (job_i.kind == b64_pkg::KIND_ERR);
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule
